### rtl/ftws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time window statistics package
// Shared types, constants and the restoring divider step.
// ----------------------------------------------------------------------------
package ftws_pkg;

    localparam int unsigned             DATA_W        = 32;
    localparam int unsigned             SMOOTH_W      = 16;
    localparam logic [SMOOTH_W-1:0]     SMOOTH_RESET  = 16'd6554;
    localparam int unsigned             RATE_NUM_W    = 42;
    localparam logic [RATE_NUM_W-1:0]   RATE_NUM      = 42'd1000 << 32;
    localparam logic [31:0]             EMA_ROUND     = 32'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_EMA,
        ST_SCAN,
        ST_RATE_DIV,
        ST_MEAN_DIV,
        ST_DONE
    } ftws_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic              qbit;
    } div_step_t;

    function automatic div_step_t div_step(
        input logic [DATA_W-1:0] rem,
        input logic              bit_in,
        input logic [DATA_W-1:0] den
    );
        logic [DATA_W:0] rem_sh;
        logic [DATA_W:0] diff;
        div_step_t       res;
        rem_sh = {rem, bit_in};
        diff   = rem_sh - {1'b0, den};
        if (rem_sh >= {1'b0, den}) begin
            res.rem  = diff[DATA_W-1:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = rem_sh[DATA_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/frame_time_window_statistics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time window statistics
// History ring in a synchronous memory, EMA of frame time, rate from the EMA,
// and min / max / mean over the valid history entries.
// ----------------------------------------------------------------------------
// No new word is accepted until the previous result has been loaded into the output
//   registers; the scan reads one ring entry per cycle from the memory port and the
//   shared divider resolves two quotient bits per cycle.
// Reset: ring empty (fill count zero), EMA and window sum zero, factor 6554.
// ----------------------------------------------------------------------------
module frame_time_window_statistics
    import ftws_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [SMOOTH_W-1:0] cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [DATA_W-1:0]   frame_time_ms,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [DATA_W-1:0]        smoothed_time_ms,
    output logic [DATA_W-1:0]        smoothed_rate_fps,
    output logic [DATA_W-1:0]        window_min_ms,
    output logic [DATA_W-1:0]        window_max_ms,
    output logic [DATA_W-1:0]        window_mean_ms
);

    localparam int unsigned ADDR_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CNT_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SUM_W    = DATA_W + CNT_W;
    localparam int unsigned NUM_MAX  = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
    localparam int unsigned DIV_W    = NUM_MAX + (NUM_MAX % 2);
    localparam int unsigned ITER     = DIV_W / 2;
    localparam int unsigned ITER_W   = $clog2(ITER);
    localparam int unsigned PA_W     = DATA_W + SMOOTH_W + 1;
    localparam int unsigned PB_W     = DATA_W + SMOOTH_W;
    localparam int unsigned ACC_W    = PA_W + 1;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITER - 1);

    logic [DATA_W-1:0] ring_mem [HISTORY_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    ftws_state_t         state_reg, state_next;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   avg_reg, avg_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic [PA_W-1:0]     prod_a_reg, prod_a_next;
    logic [PB_W-1:0]     prod_b_reg, prod_b_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic [DATA_W-1:0]   hi_reg, hi_next;
    logic [DIV_W-1:0]    num_reg, num_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   den_reg, den_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DATA_W-1:0]   rate_reg, rate_next;
    logic [DATA_W-1:0]   mean_reg, mean_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   o_time_reg, o_rate_reg, o_min_reg, o_max_reg, o_mean_reg;
    logic                out_load;

    logic                in_accept;
    logic                full;
    logic                scan_last;
    logic                div_last;
    logic [SMOOTH_W:0]   weight_old;
    logic [ACC_W-1:0]    ema_acc;
    div_step_t           step_hi, step_lo;
    logic [DIV_W-1:0]    quot;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign full      = (count_reg == FULL_CNT);
    assign scan_last = (scan_reg == count_reg);
    assign div_last  = (iter_reg == LAST_ITER);
    assign out_load  = (state_reg == ST_DONE) && !(out_valid_reg && out_stall);

    assign weight_old = (SMOOTH_W+1)'(1 << SMOOTH_W) - {1'b0, smooth_reg};
    assign ema_acc    = {1'b0, prod_a_reg} + ACC_W'(prod_b_reg) + ACC_W'(EMA_ROUND);

    assign step_hi = div_step(rem_reg, num_reg[DIV_W-1], den_reg);
    assign step_lo = div_step(step_hi.rem, num_reg[DIV_W-2], den_reg);
    assign quot    = {num_reg[DIV_W-3:0], step_hi.qbit, step_lo.qbit};

    // history ring, read-first
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ring_mem[slot_reg] <= frame_time_ms;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_accept) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_MUL;
            ST_MUL:      state_next = ST_EMA;
            ST_EMA:      state_next = ST_SCAN;
            ST_SCAN:     if (scan_last) state_next = ST_RATE_DIV;
            ST_RATE_DIV: if (div_last) state_next = ST_MEAN_DIV;
            ST_MEAN_DIV: if (div_last) state_next = ST_DONE;
            ST_DONE:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr     = slot_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        avg_next    = avg_reg;
        sum_next    = sum_reg;
        x_next      = x_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        scan_next   = scan_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        iter_next   = iter_reg;
        rate_next   = rate_reg;
        mean_next   = mean_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next = frame_time_ms;
                end
            end
            ST_UPDATE:
            begin
                // drop the oldest word once the ring is full
                sum_next    = sum_reg - (full ? SUM_W'(rd_data_reg) : '0) + SUM_W'(x_reg);
                count_next  = full ? count_reg : count_reg + 1'b1;
                slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                prod_a_next = PA_W'(avg_reg) * PA_W'(weight_old);
            end
            ST_MUL:
            begin
                prod_b_next = PB_W'(x_reg) * PB_W'(smooth_reg);
            end
            ST_EMA:
            begin
                avg_next  = ema_acc[SMOOTH_W +: DATA_W];
                rd_addr   = '0;
                scan_next = CNT_W'(1);
                lo_next   = '1;
                hi_next   = '0;
            end
            ST_SCAN:
            begin
                if (rd_data_reg < lo_reg) lo_next = rd_data_reg;
                if (rd_data_reg > hi_reg) hi_next = rd_data_reg;
                if (scan_last)
                begin
                    num_next  = DIV_W'(RATE_NUM);
                    den_next  = avg_reg;
                    rem_next  = '0;
                    iter_next = '0;
                end else begin
                    rd_addr   = scan_reg[ADDR_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_RATE_DIV:
            begin
                num_next  = quot;
                rem_next  = step_lo.rem;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                begin
                    if (avg_reg == '0)
                        rate_next = '0;
                    else if (|quot[DIV_W-1:DATA_W])
                        rate_next = '1;
                    else
                        rate_next = quot[DATA_W-1:0];
                    num_next  = DIV_W'(sum_reg);
                    den_next  = DATA_W'(count_reg);
                    rem_next  = '0;
                    iter_next = '0;
                end
            end
            ST_MEAN_DIV:
            begin
                num_next  = quot;
                rem_next  = step_lo.rem;
                iter_next = iter_reg + 1'b1;
                if (div_last)
                begin
                    mean_next = quot[DATA_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                rd_addr = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            smooth_reg    <= SMOOTH_RESET;
            slot_reg      <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            sum_reg       <= '0;
            scan_reg      <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                smooth_reg <= cfg_wdata;
            end
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            sum_reg       <= sum_next;
            scan_reg      <= scan_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        rate_reg   <= rate_next;
        mean_reg   <= mean_next;
        if (out_load)
        begin
            o_time_reg <= avg_reg;
            o_rate_reg <= rate_reg;
            o_min_reg  <= lo_reg;
            o_max_reg  <= hi_reg;
            o_mean_reg <= mean_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign smoothed_time_ms  = o_time_reg;
    assign smoothed_rate_fps = o_rate_reg;
    assign window_min_ms     = o_min_reg;
    assign window_max_ms     = o_max_reg;
    assign window_mean_ms    = o_mean_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count beyond ring depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_UPDATE)
        else $error("accepted word did not start an update");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (scan_reg != '0) && (scan_reg <= count_reg))
        else $error("scan index outside the valid entries");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside the done step");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMA |-> count_reg != '0)
        else $error("window empty after an update");

endmodule
`default_nettype wire

### dv/frame_time_window_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame time window statistics testbench
// Sends frame time words through a valid/stall handshake and checks every
// result word against an in-bench predictor. The predictor tracks the history
// ring, the EMA, the rate and min/max/mean. The run starts with directed
// extremes: zero time, rate saturation and half-up ties at the smoothing
// extremes. Random streams follow at several smoothing settings, with random
// sender gaps and receiver stalls in all but the back-to-back stream.
// ----------------------------------------------------------------------------
module frame_time_window_statistics_tb
    import ftws_pkg::*;
();

    localparam int unsigned WINDOW_DEPTH      = 64;
    localparam logic [15:0] DEFAULT_SMOOTHING = 16'd6554;
    localparam logic [63:0] RATE_DIVIDEND     = 64'd1000 << 32;
    localparam logic [63:0] RATE_MAX          = 64'hFFFF_FFFF;
    localparam int          STALL_LIMIT       = 5000;
    localparam int          SETTLE_CYCLES     = 300;

    typedef struct packed {
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] mean;
    } frame_stats_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [SMOOTH_W-1:0] cfg_wdata     = '0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [DATA_W-1:0]   frame_time_ms = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [DATA_W-1:0]   smoothed_time_ms;
    logic [DATA_W-1:0]   smoothed_rate_fps;
    logic [DATA_W-1:0]   window_min_ms;
    logic [DATA_W-1:0]   window_max_ms;
    logic [DATA_W-1:0]   window_mean_ms;

    frame_stats_t        stats_due[$];
    frame_stats_t        stats_head;

    logic [DATA_W-1:0]   hist_mem [WINDOW_DEPTH];
    int unsigned         hist_wr;
    int unsigned         hist_fill;
    logic [63:0]         hist_sum;
    logic [DATA_W-1:0]   ema_ms;
    logic [SMOOTH_W-1:0] smooth_f;

    int                  err_count    = 0;
    int                  frames_sent  = 0;
    int                  results_seen = 0;
    int                  cfg_writes   = 0;
    int                  rate_sat     = 0;
    int                  rate_zero    = 0;
    int                  ring_wraps   = 0;
    int                  idle_cycles  = 0;
    int                  stall_left   = 0;
    bit                  tx_idle_en   = 1'b1;
    bit                  rx_idle_en   = 1'b1;

    frame_time_window_statistics #(
        .HISTORY_DEPTH(WINDOW_DEPTH)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_time_ms    (frame_time_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .smoothed_time_ms (smoothed_time_ms),
        .smoothed_rate_fps(smoothed_rate_fps),
        .window_min_ms    (window_min_ms),
        .window_max_ms    (window_max_ms),
        .window_mean_ms   (window_mean_ms)
    );

    always #4 clk = ~clk;

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic logic [DATA_W-1:0] pick_frame_time(input bit small_heavy,
                                                          input logic [DATA_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (small_heavy && r < 70)
            return 32'($urandom_range(0, 2000));
        if (r < 45)
            return {16'($urandom_range(4, 100)), 16'($urandom)};
        if (r < 60)
            return 32'($urandom_range(0, 2000));
        if (r < 80)
            return $urandom;
        if (r < 88)
            return prev;
        if (r < 94)
            return '0;
        return '1;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            hist_mem[i] = '0;
        hist_wr   = 0;
        hist_fill = 0;
        hist_sum  = '0;
        ema_ms    = '0;
        smooth_f  = DEFAULT_SMOOTHING;
    endfunction

    function automatic void predict_frame(input logic [DATA_W-1:0] t);
        logic [63:0]  acc;
        logic [63:0]  quot;
        frame_stats_t s;
        // drop the oldest entry once the ring is full
        if (hist_fill == WINDOW_DEPTH)
            hist_sum -= 64'(hist_mem[hist_wr]);
        else
            hist_fill++;
        hist_mem[hist_wr] = t;
        hist_sum += 64'(t);
        if (hist_wr == WINDOW_DEPTH - 1)
        begin
            hist_wr = 0;
            ring_wraps++;
        end
        else
            hist_wr++;

        acc = 64'(ema_ms) * (64'd65536 - 64'(smooth_f)) + 64'(t) * 64'(smooth_f) + 64'd32768;
        ema_ms = acc[47:16];
        s.avg = ema_ms;
        if (ema_ms == '0)
        begin
            s.rate = '0;
            rate_zero++;
        end
        else
        begin
            quot = RATE_DIVIDEND / 64'(ema_ms);
            if (quot > RATE_MAX)
            begin
                s.rate = '1;
                rate_sat++;
            end
            else
                s.rate = quot[31:0];
        end

        s.lo = '1;
        s.hi = '0;
        for (int i = 0; i < hist_fill; i++)
        begin
            if (hist_mem[i] < s.lo)
                s.lo = hist_mem[i];
            if (hist_mem[i] > s.hi)
                s.hi = hist_mem[i];
        end
        s.mean = 32'(hist_sum / 64'(hist_fill));
        stats_due = {stats_due, s};
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            err_count++;
            $error("%s: expected %h, actual %h", name, want, got);
        end
    endfunction

    task automatic send_frame(input logic [DATA_W-1:0] t);
        int gap;
        gap = tx_idle_en ? pick_idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        frame_time_ms <= t;
        do
            @(posedge clk);
        while (in_stall);
        predict_frame(t);
        frames_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (stats_due.size() != 0);
    endtask

    task automatic write_smoothing(input logic [SMOOTH_W-1:0] f);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_we    <= 1'b0;
        smooth_f = f;
        cfg_writes++;
    endtask

    task automatic run_stream(input int count, input logic [SMOOTH_W-1:0] f,
                              input bit small_heavy, input bit idles, input int pause_at);
        logic [DATA_W-1:0] prev;
        write_smoothing(f);
        tx_idle_en = idles;
        rx_idle_en = idles;
        prev = 32'd16 << 16;
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                wait_all_results();
            prev = pick_frame_time(small_heavy, prev);
            send_frame(prev);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // reset factor, zero time, full-scale and mid-scale words
    task automatic test_reset_state_and_extremes();
        send_frame(32'd0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd1);
        send_frame(32'h0001_0000);
        send_frame(32'h8000_0000);
        send_frame(32'h7FFF_FFFF);
    endtask

    // saturating rate near 1000, EMA at full scale, frozen EMA, half-up ties
    task automatic test_smoothing_extremes();
        write_smoothing(16'hFFFF);
        send_frame(32'd1000);
        send_frame(32'd1000);
        send_frame(32'd1000);
        send_frame(32'd1001);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);
        send_frame(32'd0);
        send_frame(32'd0);
        write_smoothing(16'h0000);
        send_frame(32'd5);
        send_frame(32'h1234_5678);
        write_smoothing(16'h8000);
        send_frame(32'd1);
        send_frame(32'd0);
    endtask

    task automatic test_steady_window();
        run_stream(170, DEFAULT_SMOOTHING, 1'b0, 1'b1, -1);
    endtask

    task automatic test_back_to_back();
        run_stream(130, 16'($urandom), 1'b0, 1'b0, -1);
    endtask

    task automatic test_fast_frames();
        run_stream(110, 16'hFFFF, 1'b1, 1'b1, -1);
    endtask

    task automatic test_factor_one();
        run_stream(100, 16'd1, 1'b0, 1'b1, -1);
    endtask

    task automatic test_drain_midstream();
        run_stream(140, 16'($urandom), 1'b0, 1'b1, 70);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_idle_en)
                stall_left = pick_idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (stats_due.size() == 0)
            begin
                err_count++;
                $error("result word with no frame time pending");
            end
            else
            begin
                stats_head = stats_due[0];
                stats_due.delete(0);
                check_field("smoothed_time_ms", stats_head.avg, smoothed_time_ms);
                check_field("smoothed_rate_fps", stats_head.rate, smoothed_rate_fps);
                check_field("window_min_ms", stats_head.lo, window_min_ms);
                check_field("window_max_ms", stats_head.hi, window_max_ms);
                check_field("window_mean_ms", stats_head.mean, window_mean_ms);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("frame_time_window_statistics test failed");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state_and_extremes();
        test_smoothing_extremes();
        test_steady_window();
        test_back_to_back();
        test_fast_frames();
        test_factor_one();
        test_drain_midstream();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d frame times, checked %0d results, %0d smoothing writes",
                 frames_sent, results_seen, cfg_writes);
        $display("Rate saturated %0d times and zero %0d times; history ring wrapped %0d times",
                 rate_sat, rate_zero, ring_wraps);
        if (err_count == 0)
            $display("frame_time_window_statistics test passed");
        else
            $display("frame_time_window_statistics test failed");
        $finish;
    end

endmodule
